@@ hdl/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine: request codes,
// field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package olist_pkg;

	// Field widths of the request and result transactions
	localparam int REQ_W     = 4;
	localparam int POS_W     = 6;
	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 6;

	// Default list capacity
	localparam int DEPTH_DEF = 32;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK    = 4'd0,
		REQ_PUSH_FRONT   = 4'd1,
		REQ_INSERT_AT    = 4'd2,
		REQ_REMOVE_AT    = 4'd3,
		REQ_REMOVE_VALUE = 4'd4,
		REQ_FIND         = 4'd5,
		REQ_READ_AT      = 4'd6,
		REQ_POP_BACK     = 4'd7,
		REQ_POP_FRONT    = 4'd8
	} req_e;

	// What a cell does with its entry in one cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_PREV = 2'd2,
		CELL_NEXT = 2'd3
	} cell_op_t;

	// Control word sent to each cell
	typedef struct packed {
		cell_op_t op;      // entry update
		logic     cmp_en;  // capture a fresh match flag
		logic     live;    // cell holds a list entry
	} cell_ctl_t;

endpackage

@@ hdl/ordered_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list kept in a row of cells. Inserts open a gap by moving
// entries one cell back, removals close it by moving them one cell forward.
// ----------------------------------------------------------------------------
// Request flow: the request stage holds an accepted request and the result register
//   loads from it when it fires, later only while an earlier result is held by res_stall.
// A new request is taken only once the held one has fired; the per-cell match
//   register sits between the value compare and the shift of the cell row.
// A result may wait on res_stall while the next request is taken.
// Reset clears the entry count and all valid flags; cell entries are not reset.
module ordered_list_engine_top #(
	parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [olist_pkg::REQ_W-1:0]         req_type,
	input  logic [olist_pkg::POS_W-1:0]         position,
	input  logic signed [olist_pkg::DATA_W-1:0] value,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                ok,
	output logic signed [olist_pkg::DATA_W-1:0] read_data,
	output logic [olist_pkg::COUNT_W-1:0]       count,
	output logic                                empty_res
);
	import olist_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > POS_W) ? CW : POS_W;

	// Request stage and list state
	logic                valid_s1;
	logic [REQ_W-1:0]    req_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [DATA_W-1:0]   val_s1;
	logic [CW-1:0]       cnt_q;

	// Result register
	logic                res_valid_q;
	logic                ok_q;
	logic [DATA_W-1:0]   rd_q;
	logic [COUNT_W-1:0]  count_q;
	logic                empty_q;

	// Cell row
	cell_ctl_t           ctl   [DEPTH];
	logic [DATA_W-1:0]   cdata [DEPTH];
	logic [DEPTH-1:0]    match_vec;
	logic [DATA_W-1:0]   bcast;

	// Apply stage decode
	logic                accept;
	logic                fire;
	logic                open_ok;
	logic                close_ok;
	logic                pop_ok;
	logic                use_match;
	logic                ok_d;
	logic [DATA_W-1:0]   rd_d;
	logic [KW-1:0]       cnt_k;
	logic [KW-1:0]       pos_k;
	logic [KW-1:0]       at_k;
	logic                full;
	logic [DEPTH-1:0]    neg_match;
	logic [DEPTH-1:0]    pos_ge;
	logic [DEPTH-1:0]    pos_eq;
	logic [DEPTH-1:0]    ge_mask;
	logic [DEPTH-1:0]    eq_mask;
	logic [CW-1:0]       cnt_d;

	// Handshakes: one request in flight at a time
	assign req_stall = valid_s1;
	assign accept    = req_valid && !req_stall;
	assign fire      = valid_s1 && (!res_valid_q || !res_stall);

	// Compare against the incoming value, load the held value on apply
	assign bcast = valid_s1 ? val_s1 : $unsigned(value);

	// Build the cell row
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		olist_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[g]),
			.value_in  (bcast),
			.prev_data ((g == 0) ? cdata[g] : cdata[(g == 0) ? 0 : g - 1]),
			.next_data ((g == DEPTH - 1) ? cdata[g] :
			            cdata[(g == DEPTH - 1) ? g : g + 1]),
			.data      (cdata[g]),
			.match     (match_vec[g])
		);
	end

	// Decode the held request against the current count
	always_comb begin
		cnt_k     = KW'(cnt_q);
		pos_k     = KW'(pos_s1);
		full      = (cnt_q == CW'(DEPTH));
		open_ok   = 1'b0;
		close_ok  = 1'b0;
		pop_ok    = 1'b0;
		use_match = 1'b0;
		ok_d      = 1'b0;
		rd_d      = '0;
		at_k      = '0;
		unique case (req_s1)
			REQ_PUSH_BACK: begin
				open_ok = !full;
				at_k    = cnt_k;
			end
			REQ_PUSH_FRONT: begin
				open_ok = !full;
			end
			REQ_INSERT_AT: begin
				open_ok = !full && (pos_k <= cnt_k);
				at_k    = pos_k;
			end
			REQ_REMOVE_AT: begin
				close_ok = (pos_k < cnt_k);
				at_k     = pos_k;
			end
			REQ_REMOVE_VALUE: begin
				close_ok  = |match_vec;
				use_match = 1'b1;
			end
			REQ_FIND: begin
				ok_d = |match_vec;
			end
			REQ_READ_AT: begin
				if (pos_k < cnt_k) begin
					ok_d = 1'b1;
					rd_d = cdata[pos_k[IW-1:0]];
				end else begin
					rd_d = '1;
				end
			end
			REQ_POP_BACK: begin
				pop_ok = (cnt_q != '0);
			end
			REQ_POP_FRONT: begin
				close_ok = (cnt_q != '0);
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		if (open_ok || close_ok || pop_ok) begin
			ok_d = 1'b1;
		end
		if (open_ok) begin
			cnt_d = cnt_q + CW'(1);
		end else if (close_ok || pop_ok) begin
			cnt_d = cnt_q - CW'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	// Position masks and first-match masks
	always_comb begin
		neg_match = ~match_vec + DEPTH'(1);
		for (int i = 0; i < DEPTH; i++) begin
			pos_ge[i] = (KW'(i) >= at_k);
			pos_eq[i] = (KW'(i) == at_k);
		end
		ge_mask = use_match ? (match_vec | neg_match) : pos_ge;
		eq_mask = use_match ? (match_vec & neg_match) : pos_eq;
	end

	// Drive each cell: open a gap, close a gap or hold
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].op     = CELL_HOLD;
			ctl[i].cmp_en = accept;
			ctl[i].live   = (KW'(i) < cnt_k);
			if (fire && open_ok) begin
				if (eq_mask[i]) begin
					ctl[i].op = CELL_LOAD;
				end else if (ge_mask[i]) begin
					ctl[i].op = CELL_PREV;
				end
			end else if (fire && close_ok && ge_mask[i]) begin
				ctl[i].op = CELL_NEXT;
			end
		end
	end

	// Hold the request stage and the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			pos_s1 <= position;
			val_s1 <= $unsigned(value);
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q    <= ok_d;
			rd_q    <= rd_d;
			count_q <= COUNT_W'(cnt_d);
			empty_q <= (cnt_d == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign ok        = ok_q;
	assign read_data = $signed(rd_q);
	assign count     = count_q;
	assign empty_res = empty_q;

endmodule

@@ hdl/olist_cell.sv @@
// ----------------------------------------------------------------------------
// olist_cell
// One place of the list. Holds an entry, loads a new value or takes the
// entry of either neighbor, and flags when its entry equals the search value.
// ----------------------------------------------------------------------------
module olist_cell (
	input  logic                            clk,
	input  olist_pkg::cell_ctl_t            ctl,
	input  logic [olist_pkg::DATA_W-1:0]    value_in,
	input  logic [olist_pkg::DATA_W-1:0]    prev_data,
	input  logic [olist_pkg::DATA_W-1:0]    next_data,
	output logic [olist_pkg::DATA_W-1:0]    data,
	output logic                            match
);
	import olist_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              match_q;

	// Update the entry and capture the compare result
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: data_q <= data_q;
			CELL_LOAD: data_q <= value_in;
			CELL_PREV: data_q <= prev_data;
			CELL_NEXT: data_q <= next_data;
			default:   data_q <= data_q;
		endcase
		if (ctl.cmp_en) begin
			match_q <= ctl.live && (data_q == value_in);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

@@ hdl/olist_chk.sv @@
// ----------------------------------------------------------------------------
// olist_chk
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module olist_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_stall,
	input logic                                res_valid,
	input logic                                res_stall,
	input logic                                ok,
	input logic signed [olist_pkg::DATA_W-1:0] read_data,
	input logic [olist_pkg::COUNT_W-1:0]       count,
	input logic                                empty_res
);
	import olist_pkg::*;

	// Empty flag follows the reported count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (empty_res == (count == '0)))
		else $error("empty_res disagrees with count");

	// A failed request returns zero or the read failure marker
	a_fail_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ok |-> (read_data == '0) || (read_data == '1))
		else $error("bad read_data on failed request");

	// Only one request is in flight: stall right after a request transaction
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in flight");

	// A stalled result stays valid and unchanged
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(ok) && $stable(read_data)
			&& $stable(count))
		else $error("stalled result changed");

endmodule

bind ordered_list_engine_top olist_chk u_olist_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.ok        (ok),
	.read_data (read_data),
	.count     (count),
	.empty_res (empty_res)
);

@@ tb/ordered_list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_checker
// Watches the request and result channels of the ordered list engine. Keeps
// a shadow copy of the list, predicts the result of each accepted request
// and compares every accepted result, field by field, with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module ordered_list_checker #(
	parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [olist_pkg::REQ_W-1:0]         req_type,
	input  logic [olist_pkg::POS_W-1:0]         position,
	input  logic signed [olist_pkg::DATA_W-1:0] value,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic                                ok,
	input  logic signed [olist_pkg::DATA_W-1:0] read_data,
	input  logic [olist_pkg::COUNT_W-1:0]       count,
	input  logic                                empty_res,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  results_checked,
	output int                                  full_rejects,
	output int                                  peak_fill
);
	import olist_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct {
		logic                     ok;
		logic signed [DATA_W-1:0] read_data;
		logic [COUNT_W-1:0]       count;
		logic                     empty_res;
	} list_result_t;

	// Shadow of the list contents, front at index 0
	logic signed [DATA_W-1:0] shadow_list [DEPTH];
	int                       shadow_len;
	list_result_t             expected_results [$];

	// Print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP) begin
			$display("[%0t ns] mismatch: %s", $time, msg);
		end
		mismatches++;
	endtask

	// Shift entries back from the insert point and drop the new entry in
	function automatic void open_slot(input int at, input logic signed [DATA_W-1:0] v);
		for (int i = shadow_len; i > at; i--) begin
			shadow_list[i] = shadow_list[i-1];
		end
		shadow_list[at] = v;
		shadow_len++;
	endfunction

	// Shift entries forward over the removed one
	function automatic void close_slot(input int at);
		for (int i = at; i + 1 < shadow_len; i++) begin
			shadow_list[i] = shadow_list[i+1];
		end
		shadow_len--;
	endfunction

	// Apply one request to the shadow list and return its result
	function automatic list_result_t apply_request(
		input logic [REQ_W-1:0]         kind,
		input logic [POS_W-1:0]         pos,
		input logic signed [DATA_W-1:0] val
	);
		list_result_t r;
		int           at;
		int           hit;
		at          = int'(pos);
		hit         = -1;
		r.ok        = 1'b0;
		r.read_data = '0;
		if (kind == REQ_REMOVE_VALUE || kind == REQ_FIND) begin
			for (int i = 0; i < shadow_len; i++) begin
				if (hit < 0 && shadow_list[i] == val) hit = i;
			end
		end
		case (req_e'(kind))
			REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT_AT: begin
				if (shadow_len >= DEPTH) begin
					full_rejects++;
				end else if (kind == REQ_PUSH_BACK) begin
					open_slot(shadow_len, val);
					r.ok = 1'b1;
				end else if (kind == REQ_PUSH_FRONT) begin
					open_slot(0, val);
					r.ok = 1'b1;
				end else if (at <= shadow_len) begin
					open_slot(at, val);
					r.ok = 1'b1;
				end
			end
			REQ_REMOVE_AT: begin
				if (at < shadow_len) begin
					close_slot(at);
					r.ok = 1'b1;
				end
			end
			REQ_REMOVE_VALUE: begin
				if (hit >= 0) begin
					close_slot(hit);
					r.ok = 1'b1;
				end
			end
			REQ_FIND: begin
				r.ok = (hit >= 0);
			end
			REQ_READ_AT: begin
				if (at < shadow_len) begin
					r.read_data = shadow_list[at];
					r.ok        = 1'b1;
				end else begin
					r.read_data = -32'sd1;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_len > 0) begin
					shadow_len--;
					r.ok = 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_len > 0) begin
					close_slot(0);
					r.ok = 1'b1;
				end
			end
			default: begin
				// unused request codes leave the list alone
			end
		endcase
		r.count     = COUNT_W'(shadow_len);
		r.empty_res = (shadow_len == 0);
		if (shadow_len > peak_fill) peak_fill = shadow_len;
		return r;
	endfunction

	// Check results first, then log the request taken on the same edge
	always @(posedge clk) begin : watch_channels
		list_result_t want;
		if (!arst_n) begin
			foreach (shadow_list[i]) shadow_list[i] = '0;
			shadow_len = 0;
			expected_results.delete();
			mismatches      = 0;
			results_checked = 0;
			full_rejects    = 0;
			peak_fill       = 0;
		end else begin
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with no request outstanding (ok=%0b count=%0d)",
						ok, count));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (ok !== want.ok)
						report_mismatch($sformatf("ok: expected %0b, got %0b", want.ok, ok));
					if (read_data !== want.read_data)
						report_mismatch($sformatf("read_data: expected %0d, got %0d",
							want.read_data, read_data));
					if (count !== want.count)
						report_mismatch($sformatf("count: expected %0d, got %0d", want.count, count));
					if (empty_res !== want.empty_res)
						report_mismatch($sformatf("empty_res: expected %0b, got %0b",
							want.empty_res, empty_res));
				end
			end
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				expected_results.push_back(apply_request(req_type, position, value));
			end
		end
		outstanding <= expected_results.size();
	end

endmodule

@@ tb/tb_ordered_list_engine_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// Drives the ordered list engine with a directed pass over the empty-list
// and bad-index cases, then with random runs that grow, drain and churn the
// list, under three idling patterns and long result hold-offs. Prediction
// and checking live in ordered_list_checker.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
	import olist_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int SETTLE       = 10;

	// Request codes the block does not implement
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd9;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

	localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

	typedef enum int {FILL_UP, DRAIN, CHURN} fill_mode_e;

	logic                     clk       = 1'b0;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic [REQ_W-1:0]         req_type;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic                     ok;
	logic signed [DATA_W-1:0] read_data;
	logic [COUNT_W-1:0]       count;
	logic                     empty_res;

	int mismatches;
	int outstanding;
	int results_checked;
	int full_rejects;
	int peak_fill;

	// 0: sender 28 / receiver 46 percent idle, 1: swapped, 2: no idling
	int idle_phase = 0;
	int seen_phase = 0;
	int hold_left  = 0;
	int sent       = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ordered_list_engine_top dut (.*);

	ordered_list_checker #(.DEPTH(DEPTH)) u_checker (.*);

	// Receiver: long hold-off at each phase change, then random stalls
	always @(posedge clk) begin
		if (idle_phase != seen_phase) begin
			seen_phase <= idle_phase;
			hold_left  <= LONG_HOLD;
			res_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			case (idle_phase)
				0:       res_stall <= ($urandom_range(0, 99) < 46);
				1:       res_stall <= ($urandom_range(0, 99) < 28);
				default: res_stall <= 1'b0;
			endcase
		end
	end

	// Offer one transaction, with random idle cycles first, and hold it until taken
	task automatic send_request(
		input logic [REQ_W-1:0]         kind,
		input logic [POS_W-1:0]         pos,
		input logic signed [DATA_W-1:0] val
	);
		int pct;
		pct = (idle_phase == 0) ? 28 : (idle_phase == 1) ? 46 : 0;
		while (pct > 0 && $urandom_range(0, 99) < pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		position  <= pos;
		value     <= val;
		do @(posedge clk); while (req_stall !== 1'b0);
		sent++;
	endtask

	initial begin
		fill_mode_e               mode;
		int                       episode_left;
		int                       roll;
		int                       drain_cycles;
		logic [REQ_W-1:0]         kind;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;

		episode_left = 0;
		mode         = CHURN;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_type  <= '0;
		position  <= '0;
		value     <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, unknown codes, extremes, index bounds, duplicates
		send_request(REQ_POP_FRONT, 6'd0, 32'sd0);
		send_request(REQ_POP_BACK, 6'd0, 32'sd0);
		send_request(REQ_REMOVE_AT, 6'd0, 32'sd0);
		send_request(REQ_REMOVE_VALUE, 6'd0, 32'sd0);
		send_request(REQ_FIND, 6'd0, 32'sd0);
		send_request(REQ_READ_AT, 6'd0, 32'sd0);
		send_request(REQ_UNUSED_LO, 6'd0, DATA_MAX);
		send_request(REQ_PUSH_BACK, 6'd0, DATA_MAX);
		send_request(REQ_PUSH_FRONT, 6'd0, DATA_MIN);
		send_request(REQ_INSERT_AT, 6'd1, -32'sd1);
		send_request(REQ_INSERT_AT, 6'd3, 32'sd5);
		send_request(REQ_INSERT_AT, 6'd5, 32'sd9);
		send_request(REQ_INSERT_AT, 6'd63, 32'sd9);
		send_request(REQ_PUSH_BACK, 6'd0, -32'sd1);
		send_request(REQ_READ_AT, 6'd0, 32'sd0);
		send_request(REQ_READ_AT, 6'd4, 32'sd0);
		send_request(REQ_READ_AT, 6'd5, 32'sd0);
		send_request(REQ_READ_AT, 6'd63, 32'sd0);
		send_request(REQ_FIND, 6'd0, 32'sd5);
		send_request(REQ_FIND, 6'd0, 32'sd12345);
		send_request(REQ_REMOVE_VALUE, 6'd0, -32'sd1);
		send_request(REQ_REMOVE_VALUE, 6'd0, 32'sd777);
		send_request(REQ_REMOVE_AT, 6'd3, 32'sd0);
		send_request(REQ_REMOVE_AT, 6'd0, 32'sd0);
		send_request(REQ_POP_BACK, 6'd0, 32'sd0);
		send_request(REQ_POP_FRONT, 6'd0, 32'sd0);
		send_request(REQ_UNUSED_HI, 6'd63, DATA_MIN);

		// Random: episodes that fill up, drain or churn the list
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) idle_phase <= 1;
			else if (n == 2 * RANDOM_ITEMS / 3) idle_phase <= 2;
			if (episode_left == 0) begin
				mode         = fill_mode_e'($urandom_range(0, 2));
				episode_left = $urandom_range(10, 60);
			end
			episode_left--;

			roll = $urandom_range(0, 99);
			case (mode)
				FILL_UP: kind = (roll < 75) ? REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_INSERT_AT))
				                            : REQ_W'($urandom_range(REQ_REMOVE_AT, REQ_POP_FRONT));
				DRAIN: begin
					if (roll < 35)      kind = REQ_W'($urandom_range(REQ_REMOVE_AT, REQ_REMOVE_VALUE));
					else if (roll < 70) kind = REQ_W'($urandom_range(REQ_POP_BACK, REQ_POP_FRONT));
					else                kind = REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_READ_AT));
				end
				default: kind = (roll < 4) ? REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))
				                           : REQ_W'($urandom_range(REQ_PUSH_BACK, REQ_POP_FRONT));
			endcase

			// Mostly a small value pool so finds and removals hit
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				val = $signed(DATA_W'($urandom_range(0, 6))) - 32'sd3;
			end else if (roll < 80) begin
				val = $urandom();
			end else begin
				case ($urandom_range(0, 3))
					0:       val = DATA_MAX;
					1:       val = DATA_MIN;
					2:       val = -32'sd1;
					default: val = 32'sd0;
				endcase
			end

			roll = $urandom_range(0, 99);
			if (roll < 50)      pos = POS_W'($urandom_range(0, DEPTH + 1));
			else if (roll < 75) pos = POS_W'($urandom_range(0, 4));
			else                pos = POS_W'($urandom_range(0, 63));

			send_request(kind, pos, val);
		end
		req_valid <= 1'b0;

		// Drain: wait for outstanding results, then let the pipeline settle
		drain_cycles = 0;
		while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE) @(posedge clk);

		if (outstanding != 0) $display("%0d results never arrived", outstanding);
		$display("Ran %0d requests, %0d results compared, %0d mismatches.",
			sent, results_checked, mismatches);
		$display("Peak fill %0d of %0d entries, %0d adds refused on a full list.",
			peak_fill, DEPTH, full_rejects);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
